@@ hdl/lpsc_pkg.sv @@
// Shared types, constants and helpers for the length-prefix to start-code converter.
package lpsc_pkg;

	localparam int BYTE_W     = 8;
	localparam int LEN_W      = 32;
	localparam int PCNT_W     = 2;
	localparam int CFG_W      = 2;
	localparam int SC_LEN     = 4;
	localparam int SC_CNT_W   = $clog2(SC_LEN + 2);
	localparam int USER_W     = 2;

	// Prefix of four bytes after reset.
	localparam logic [CFG_W-1:0] PREFIX_LEN_M1_RST = 2'd3;

	// Start code, first byte sent first.
	localparam logic [BYTE_W-1:0] SC_SEQ [SC_LEN] = '{8'h00, 8'h00, 8'h00, 8'h01};

	// Bit positions inside the output tuser.
	localparam int USER_SC_BIT  = 0;
	localparam int USER_ERR_BIT = 1;

	// Work for one input item, as handed from the framer to the emitter.
	typedef struct packed {
		logic              sc;      // start code goes out first
		logic              byte_v;  // the input byte goes out
		logic [BYTE_W-1:0] data;
		logic              err;     // buffer ended inside a payload
	} plan_t;

	// Start-code byte for a count of start-code bytes still to send.
	function automatic logic [BYTE_W-1:0] sc_seq_byte(input logic [SC_CNT_W-1:0] left);
		logic [SC_CNT_W-1:0] idx;
		idx = SC_CNT_W'(SC_LEN) - left;
		return SC_SEQ[idx[$clog2(SC_LEN)-1:0]];
	endfunction

endpackage

@@ hdl/lpsc_framer.sv @@
// Prefix gathering and payload tracking; turns one registered input item into a plan.
module lpsc_framer
	import lpsc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic              eob,
	input  logic [CFG_W-1:0]  prefix_len_minus_one,
	output plan_t             plan,
	output logic              plan_v
);

	logic              in_payload_q;
	logic [PCNT_W-1:0] prefix_count_q;
	logic [LEN_W-1:0]  length_accum_q;
	logic [LEN_W-1:0]  payload_left_q;
	logic              start_pending_q;

	logic              in_payload_d;
	logic [PCNT_W-1:0] prefix_count_d;
	logic [LEN_W-1:0]  length_accum_d;
	logic [LEN_W-1:0]  payload_left_d;
	logic              start_pending_d;
	logic              send_sc;
	logic              pass_byte;
	logic [LEN_W-1:0]  shifted;

	// Decide what this item causes and where the state goes next.
	always_comb begin
		send_sc         = in_payload_q && start_pending_q;
		// A zero-length unit ends with its start code; the byte starts a new prefix.
		pass_byte       = in_payload_q && !(send_sc && (payload_left_q == '0));
		shifted         = {length_accum_q[LEN_W-BYTE_W-1:0], in_byte};
		in_payload_d    = pass_byte;
		prefix_count_d  = prefix_count_q;
		length_accum_d  = length_accum_q;
		payload_left_d  = payload_left_q;
		start_pending_d = start_pending_q && !send_sc;
		plan.sc         = send_sc;
		plan.byte_v     = pass_byte;
		plan.data       = in_byte;
		plan.err        = 1'b0;
		if (pass_byte) begin
			payload_left_d = payload_left_q - LEN_W'(1);
			if (payload_left_q == LEN_W'(1)) begin
				in_payload_d = 1'b0;
			end else if (eob) begin
				plan.err = 1'b1;
			end
		end else if (prefix_count_q >= prefix_len_minus_one) begin
			payload_left_d  = shifted;
			in_payload_d    = 1'b1;
			start_pending_d = 1'b1;
			prefix_count_d  = '0;
			length_accum_d  = '0;
		end else begin
			length_accum_d  = shifted;
			prefix_count_d  = prefix_count_q + PCNT_W'(1);
		end
		// The end of the buffer returns every unit to its reset state.
		if (eob) begin
			in_payload_d    = 1'b0;
			prefix_count_d  = '0;
			length_accum_d  = '0;
			payload_left_d  = '0;
			start_pending_d = 1'b0;
		end
		plan_v = take && (send_sc || pass_byte);
	end

	// Framing state advances once per consumed item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q    <= 1'b0;
			prefix_count_q  <= '0;
			length_accum_q  <= '0;
			payload_left_q  <= '0;
			start_pending_q <= 1'b0;
		end else if (take) begin
			in_payload_q    <= in_payload_d;
			prefix_count_q  <= prefix_count_d;
			length_accum_q  <= length_accum_d;
			payload_left_q  <= payload_left_d;
			start_pending_q <= start_pending_d;
		end
	end

endmodule

@@ hdl/lpsc_emitter.sv @@
// Holds one plan and sends its results one per cycle through the output register while the output is not stalled.
module lpsc_emitter
	import lpsc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              plan_v,
	input  plan_t             plan,
	output logic              plan_free,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [BYTE_W-1:0] m_tdata,
	output logic [USER_W-1:0] m_tuser,
	output logic              m_tlast
);

	logic [SC_CNT_W-1:0] sc_left_q;
	logic                byte_v_q;
	logic [BYTE_W-1:0]   data_q;
	logic                err_q;
	logic                m_tvalid_q;
	logic [BYTE_W-1:0]   m_tdata_q;
	logic [USER_W-1:0]   m_tuser_q;
	logic                m_tlast_q;

	logic [SC_CNT_W-1:0] remaining;
	logic                out_load;
	logic                emit;
	logic [BYTE_W-1:0]   nxt_data;
	logic                nxt_sc;
	logic                nxt_last;
	logic                nxt_err;

	// Pick the next result from the held plan.
	always_comb begin
		remaining = sc_left_q + SC_CNT_W'(byte_v_q);
		out_load  = !m_tvalid_q || m_tready;
		emit      = out_load && (remaining != '0);
		plan_free = (remaining == '0) || ((remaining == SC_CNT_W'(1)) && out_load);
		if (sc_left_q != '0) begin
			nxt_data = sc_seq_byte(sc_left_q);
			nxt_sc   = 1'b1;
			nxt_last = (sc_left_q == SC_CNT_W'(1)) && !byte_v_q;
			nxt_err  = 1'b0;
		end else begin
			nxt_data = data_q;
			nxt_sc   = 1'b0;
			nxt_last = 1'b1;
			nxt_err  = err_q;
		end
	end

	// Plan bookkeeping and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_left_q  <= '0;
			byte_v_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (plan_v) begin
				sc_left_q <= plan.sc ? SC_CNT_W'(SC_LEN) : '0;
				byte_v_q  <= plan.byte_v;
			end else if (emit) begin
				if (sc_left_q != '0) begin
					sc_left_q <= sc_left_q - SC_CNT_W'(1);
				end else begin
					byte_v_q <= 1'b0;
				end
			end
			if (out_load) begin
				m_tvalid_q <= emit;
			end
		end
	end

	// Payload of the plan and of the output register.
	always_ff @(posedge clk) begin
		if (plan_v) begin
			data_q <= plan.data;
			err_q  <= plan.err;
		end
		if (emit) begin
			m_tdata_q               <= nxt_data;
			m_tuser_q[USER_SC_BIT]  <= nxt_sc;
			m_tuser_q[USER_ERR_BIT] <= nxt_err;
			m_tlast_q               <= nxt_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

@@ hdl/length_prefix_to_start_code.sv @@
// Top level of the length-prefix to start-code stream converter.
//
//   channel  | direction | fields
//   ---------+-----------+-------------------------------------------------
//   s_*      | in        | tdata = in_byte, tlast = end_of_buffer
//   m_*      | out       | tdata = out_byte, tuser = {error, is_start_code},
//            |           | tlast = last_of_run
//   cfg_*    | in        | prefix_len_minus_one, written when cfg_we is high
//
// A payload byte passes through an input register, the framing logic with its plan
// register, and the output register. The first payload byte of a unit carries the
// start code ahead of it and holds the input while the emitter sends the five
// results. Reset clears all framing state and sets a four-byte prefix; a stall on the
// output backs up through the plan register to s_tready.
module length_prefix_to_start_code
	import lpsc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [BYTE_W-1:0] s_tdata,   // [7:0] in_byte
	input  logic              s_tlast,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [BYTE_W-1:0] m_tdata,   // [7:0] out_byte
	output logic [USER_W-1:0] m_tuser,   // [0] is_start_code, [1] error
	output logic              m_tlast,
	input  logic              cfg_we,
	input  logic [CFG_W-1:0]  cfg_wdata
);

	logic               valid_s1;
	logic [BYTE_W-1:0]  byte_s1;
	logic               eob_s1;
	logic [CFG_W-1:0]   prefix_len_minus_one_q;
	logic               take;
	logic               plan_free;
	logic               plan_v;
	plan_t              plan;

	// The registered item is consumed once the emitter can hold its plan.
	assign take     = valid_s1 && plan_free;
	assign s_tready = !valid_s1 || plan_free;

	// Input register valid and configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1               <= 1'b0;
			prefix_len_minus_one_q <= PREFIX_LEN_M1_RST;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (cfg_we) begin
				prefix_len_minus_one_q <= cfg_wdata;
			end
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			eob_s1  <= s_tlast;
		end
	end

	lpsc_framer u_framer (
		.clk                  (clk),
		.arst_n               (arst_n),
		.take                 (take),
		.in_byte              (byte_s1),
		.eob                  (eob_s1),
		.prefix_len_minus_one (prefix_len_minus_one_q),
		.plan                 (plan),
		.plan_v               (plan_v)
	);

	lpsc_emitter u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.plan_v    (plan_v),
		.plan      (plan),
		.plan_free (plan_free),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

@@ verif/length_prefix_to_start_code_test.sv @@
// Self-checking testbench for the length-prefix to start-code stream converter.
`timescale 1ns / 100ps

module length_prefix_to_start_code_test
	import lpsc_pkg::*;
();

	// One output byte as the converter should send it.
	typedef struct {
		logic [BYTE_W-1:0] data;
		logic              sc;
		logic              last;
		logic              err;
	} framed_byte_t;

	// Tracks the framing state of the converter and checks every output byte in order.
	class framing_scoreboard;
		framed_byte_t      expected_q[$];
		logic [CFG_W-1:0]  prefix_m1;
		logic              in_unit;
		logic              sc_pending;
		logic [PCNT_W-1:0] prefix_cnt;
		logic [LEN_W-1:0]  len_accum;
		logic [LEN_W-1:0]  bytes_left;
		int                fail_count;
		int                n_inputs;
		int                n_results;
		int                n_sc_bytes;
		int                n_err_flags;

		function new();
			prefix_m1   = PREFIX_LEN_M1_RST;
			fail_count  = 0;
			n_inputs    = 0;
			n_results   = 0;
			n_sc_bytes  = 0;
			n_err_flags = 0;
			clear_unit();
		endfunction

		function void clear_unit();
			in_unit    = 1'b0;
			sc_pending = 1'b0;
			prefix_cnt = '0;
			len_accum  = '0;
			bytes_left = '0;
		endfunction

		function void set_prefix(logic [CFG_W-1:0] value);
			prefix_m1 = value;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void flag_fail(string msg);
			fail_count++;
			if (fail_count <= 10) begin
				$display("MISMATCH: %s", msg);
			end
		endfunction

		// Works out the output bytes caused by one accepted input item.
		function void note_input(logic [BYTE_W-1:0] b, logic eob);
			framed_byte_t r;
			int           first;
			logic         err;
			first = expected_q.size();
			err   = 1'b0;
			n_inputs++;
			r.last = 1'b0;
			r.err  = 1'b0;

			// A unit whose length is known sends its start code ahead of the first byte.
			if (in_unit && sc_pending) begin
				for (int k = 0; k < SC_LEN; k++) begin
					r.data = SC_SEQ[k];
					r.sc   = 1'b1;
					expected_q.push_back(r);
				end
				sc_pending = 1'b0;
				if (bytes_left == 0) begin
					in_unit = 1'b0;
				end
			end

			if (in_unit) begin
				// Payload byte passes through; an early end of buffer is an error.
				r.data = b;
				r.sc   = 1'b0;
				expected_q.push_back(r);
				bytes_left--;
				if (bytes_left == 0) begin
					in_unit = 1'b0;
				end else if (eob) begin
					err = 1'b1;
				end
			end else begin
				// Big-endian prefix byte.
				len_accum = {len_accum[LEN_W-BYTE_W-1:0], b};
				if (prefix_cnt >= prefix_m1) begin
					bytes_left = len_accum;
					in_unit    = 1'b1;
					sc_pending = 1'b1;
					prefix_cnt = '0;
					len_accum  = '0;
				end else begin
					prefix_cnt++;
				end
			end

			if (eob) begin
				clear_unit();
			end

			if (expected_q.size() > first) begin
				r      = expected_q.pop_back();
				r.last = 1'b1;
				r.err  = err;
				expected_q.push_back(r);
			end
		endfunction

		// Compares one accepted output byte with the oldest expectation.
		function void check_output(logic [BYTE_W-1:0] data, logic [USER_W-1:0] user,
				logic last);
			framed_byte_t want;
			n_results++;
			if (user[USER_SC_BIT] === 1'b1) begin
				n_sc_bytes++;
			end
			if (user[USER_ERR_BIT] === 1'b1) begin
				n_err_flags++;
			end
			if (expected_q.size() == 0) begin
				flag_fail($sformatf("unexpected byte %02h sc %0b err %0b last %0b",
					data, user[USER_SC_BIT], user[USER_ERR_BIT], last));
				return;
			end
			want = expected_q.pop_front();
			if (data !== want.data || user[USER_SC_BIT] !== want.sc ||
					user[USER_ERR_BIT] !== want.err || last !== want.last) begin
				flag_fail($sformatf({"byte %0d: expected %02h sc %0b err %0b last %0b, ",
					"got %02h sc %0b err %0b last %0b"}, n_results,
					want.data, want.sc, want.err, want.last,
					data, user[USER_SC_BIT], user[USER_ERR_BIT], last));
			end
		endfunction

		// Anything still waiting at the end never came out.
		function void close_out();
			framed_byte_t want;
			while (expected_q.size() > 0) begin
				want = expected_q.pop_front();
				flag_fail($sformatf("missing byte %02h sc %0b err %0b last %0b",
					want.data, want.sc, want.err, want.last));
			end
		endfunction
	endclass

	localparam int CLK_HALF       = 6;
	localparam int RESET_CYCLES   = 11;
	localparam int IDLE_PCT       = 11;
	localparam int SETTLE_CYCLES  = 8;
	localparam int RX_HOLD_CYCLES = 80;
	localparam int PHASE_ITEMS    = 8;
	localparam int NUM_PHASES     = 5;
	localparam int PRESSURE_PHASE = 2;
	localparam int CYCLE_LIMIT    = 200000;

	localparam logic [CFG_W-1:0] PHASE_SIZES [4] = '{2'd1, 2'd2, 2'd0, 2'd3};

	// How a unit of the stream is closed off.
	typedef enum {UNIT_CLEAN, UNIT_IN_PREFIX, UNIT_IN_PAYLOAD} unit_end_e;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [BYTE_W-1:0] s_tdata;   // [7:0] in_byte
	logic              s_tlast;
	logic              m_tvalid;
	logic              m_tready;
	logic [BYTE_W-1:0] m_tdata;   // [7:0] out_byte
	logic [USER_W-1:0] m_tuser;   // [0] is_start_code, [1] error
	logic              m_tlast;
	logic              cfg_we;
	logic [CFG_W-1:0]  cfg_wdata;

	framing_scoreboard sb = new();

	logic [CFG_W-1:0] cur_prefix_m1;
	bit               tx_idle_on;
	bit               rx_idle_on;
	bit               hold_req;
	int               hold_left;
	int               items_sent;
	int               cycle_count;

	length_prefix_to_start_code u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Watchdog on the total run length.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		m_tready  = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = RX_HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= !(rx_idle_on && $urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// Both handshakes are sampled at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				sb.note_input(s_tdata, s_tlast);
			end
			if (m_tvalid && m_tready) begin
				sb.check_output(m_tdata, m_tuser, m_tlast);
			end
		end
	end

	// Offers one item, with random gaps ahead of it, and returns at the falling
	// edge after it was taken.
	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eob);
		while (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= eob;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// Stops sending and waits until every expected byte has come out.
	task automatic drain_outputs();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_prefix(input logic [CFG_W-1:0] value);
		drain_outputs();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		sb.set_prefix(value);
		cur_prefix_m1 = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Sends one unit: prefix of the current size, then payload, closed as asked.
	task automatic send_unit(input logic [LEN_W-1:0] len, input unit_end_e how, input bit closes);
		int nbytes;
		int cut;
		nbytes = int'(cur_prefix_m1) + 1;
		case (how)
			UNIT_CLEAN: begin
				for (int i = nbytes - 1; i >= 0; i--) begin
					send_byte(len[BYTE_W*i +: BYTE_W], closes && len == 0 && i == 0);
				end
				for (int i = 0; i < int'(len); i++) begin
					send_byte(BYTE_W'($urandom_range(255)), closes && i == int'(len) - 1);
				end
			end
			UNIT_IN_PREFIX: begin
				// Ends inside the prefix or on its last byte.
				cut = $urandom_range(nbytes, 1);
				for (int i = 0; i < cut; i++) begin
					send_byte(len[BYTE_W*(nbytes-1-i) +: BYTE_W], i == cut - 1);
				end
			end
			UNIT_IN_PAYLOAD: begin
				for (int i = nbytes - 1; i >= 0; i--) begin
					send_byte(len[BYTE_W*i +: BYTE_W], 1'b0);
				end
				cut = $urandom_range((len - 1 > 12) ? 12 : int'(len - 1), 1);
				for (int i = 0; i < cut; i++) begin
					send_byte(BYTE_W'($urandom_range(255)), i == cut - 1);
				end
			end
			default: ;
		endcase
	endtask

	// One input buffer: mostly well-formed units, sometimes cut short, sometimes noise.
	task automatic send_buffer();
		int               units;
		int               pick;
		int               nbytes;
		logic [LEN_W-1:0] len;
		if ($urandom_range(99) < 10) begin
			units = $urandom_range(6, 1);
			for (int i = 0; i < units; i++) begin
				send_byte(BYTE_W'($urandom_range(255)), i == units - 1 || $urandom_range(3) == 0);
			end
		end else begin
			units  = $urandom_range(3, 1);
			nbytes = int'(cur_prefix_m1) + 1;
			for (int u = 0; u < units; u++) begin
				pick = $urandom_range(99);
				if (u < units - 1 || pick < 60) begin
					pick = $urandom_range(99);
					len  = (pick < 70) ? $urandom_range(4, 0) :
						(pick < 95) ? $urandom_range(16, 5) : $urandom_range(40, 17);
					send_unit(len, UNIT_CLEAN, u == units - 1);
				end else if (pick < 80) begin
					len = $urandom_range(14, 2);
					if ($urandom_range(3) == 0) begin
						// Declared length anywhere in the prefix range.
						len = $urandom;
						if (nbytes < 4) begin
							len &= (32'd1 << (BYTE_W * nbytes)) - 1;
						end
						if (len < 2) begin
							len = 2;
						end
					end
					send_unit(len, UNIT_IN_PAYLOAD, 1'b1);
				end else begin
					send_unit(LEN_W'($urandom), UNIT_IN_PREFIX, 1'b1);
				end
			end
		end
	endtask

	// Main sequence.
	initial begin
		int target;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tlast       = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		tx_idle_on    = 1'b1;
		rx_idle_on    = 1'b1;
		hold_req      = 1'b0;
		items_sent    = 0;
		cur_prefix_m1 = PREFIX_LEN_M1_RST;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Four-byte prefix after reset: a plain two-byte unit.
		send_unit(32'd2, UNIT_CLEAN, 1'b0);
		// Zero-length unit: its start code rides on the first byte of the next prefix.
		send_unit(32'd0, UNIT_CLEAN, 1'b0);
		send_unit(32'd1, UNIT_CLEAN, 1'b1);
		// Longest declared length, buffer ends two bytes into the payload.
		for (int i = 0; i < 4; i++) begin
			send_byte(8'hFF, 1'b0);
		end
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		// Prefix size shrinks while two prefix bytes are already held.
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		write_prefix(2'd0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h5A, 1'b0);
		// Buffer ends right on a complete prefix byte.
		send_byte(8'h07, 1'b1);
		// Zero-length unit whose next byte closes the buffer.
		send_unit(32'd0, UNIT_CLEAN, 1'b0);
		send_byte(8'h33, 1'b1);

		// Random phases, one prefix size each.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			write_prefix(ph < 4 ? PHASE_SIZES[ph] : CFG_W'($urandom_range(3)));
			if (ph == PRESSURE_PHASE) begin
				// Full-rate sending against a receiver that holds off for a while.
				tx_idle_on = 1'b0;
				rx_idle_on = 1'b0;
				hold_req   = 1'b1;
			end else begin
				tx_idle_on = 1'b1;
				rx_idle_on = 1'b1;
			end
			target = items_sent + PHASE_ITEMS;
			while (sb.n_inputs < target + 28) begin
				send_buffer();
				items_sent = sb.n_inputs - 28;
			end
		end

		drain_outputs();
		sb.close_out();
		$display("summary: %0d input items, %0d output bytes (%0d start-code bytes, %0d errors)",
			sb.n_inputs, sb.n_results, sb.n_sc_bytes, sb.n_err_flags);
		$display("summary: prefix sizes 1 to 4, zero-length and long units, early buffer ends");
		if (sb.fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
